[design/nbt_pkg.sv]
// ----------------------------------------------------------------------------
// nbt_pkg
// types, codes and helper functions shared by the neighbor beacon table
// ----------------------------------------------------------------------------
package nbt_pkg;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int RESULT_LIMIT = 16;
    localparam int SNAP_CNT_W   = $clog2(RESULT_LIMIT + 1);

    typedef enum logic [1:0] {
        CMD_UPDATE   = 2'd0,
        CMD_RELAY    = 2'd1,
        CMD_TIER     = 2'd2,
        CMD_SNAPSHOT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_NEW     = 2'd0,
        ST_UPDATED = 2'd1,
        ST_SELF    = 2'd2,
        ST_OLD     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        TIER_LIVE  = 2'd0,
        TIER_STALE = 2'd1,
        TIER_GHOST = 2'd2,
        TIER_GONE  = 2'd3
    } t_tier;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SELF_ID = 3'd0,
        CFG_RESYNC  = 3'd1,
        CFG_STALE   = 3'd2,
        CFG_GHOST   = 3'd3,
        CFG_GONE    = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SNAP_ADDR,
        S_SNAP_EVAL,
        S_SNAP_END
    } t_state;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  sender_id;
        logic        relayed_flag;
        logic [15:0] beacon_seq;
        logic [7:0]  initial_first;
        logic [7:0]  initial_second;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        t_status     update_status;
        logic        relay_ok;
        t_tier       age_tier;
        logic        entry_valid;
        logic [7:0]  entry_id;
        logic [7:0]  entry_initial_first;
        logic [7:0]  entry_initial_second;
        logic [15:0] entry_seq;
        logic [31:0] entry_heard_ms;
        logic        entry_via_relay;
        logic        last_of_run;
    } t_out;

    // one table entry as held in the ram
    typedef struct packed {
        logic [15:0] initials;
        logic [15:0] stored_seq;
        logic [31:0] last_heard;
        logic        relayed;
        logic [15:0] relayed_seq;
    } t_entry;

    // 16-bit serial number compare: a newer than b
    function automatic logic seq_newer(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return (d != 16'd0) && !d[15];
    endfunction

    function automatic t_tier tier_of(input logic [31:0] age, input logic [31:0] stale,
                                      input logic [31:0] ghost, input logic [31:0] gone);
        t_tier t;
        if (age < stale) begin
            t = TIER_LIVE;
        end else if (age < ghost) begin
            t = TIER_STALE;
        end else if (age < gone) begin
            t = TIER_GHOST;
        end else begin
            t = TIER_GONE;
        end
        return t;
    endfunction

endpackage

[design/nbt_ram.sv]
// ----------------------------------------------------------------------------
// nbt_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module nbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/neighbor_beacon_table.sv]
// ----------------------------------------------------------------------------
// neighbor_beacon_table
// neighbor table indexed by sender id: beacon update, relay check, tier
// query and snapshot over entries held in one ram
// ----------------------------------------------------------------------------
// update, relay check and tier query: ram read on the accept, then modify and
//   write back in S_EXEC, which registers the result once the output is free
// snapshot: an address and an evaluate state per entry, one ram read at a time
// in-use and relay-memory valid bits sit in flops and clear at reset, so the
//   table is empty right after reset with no clearing pass; config registers
//   reset to their defaults
module neighbor_beacon_table #(
    parameter int MAX_UNITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [nbt_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [nbt_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  nbt_pkg::t_in                        i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output nbt_pkg::t_out                       o_out
);

    import nbt_pkg::*;

    localparam int AW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam logic [7:0]    UNIT_CNT = 8'(MAX_UNITS);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_UNITS - 1);
    localparam int EW = $bits(t_entry);

    t_state                r_state, n_state;
    logic [7:0]            r_cfg_self;
    logic [31:0]           r_cfg_resync, r_cfg_stale, r_cfg_ghost, r_cfg_gone;
    t_in                   r_item;
    logic [MAX_UNITS-1:0]  r_in_use, n_in_use;
    logic [MAX_UNITS-1:0]  r_any_rel, n_any_rel;
    logic [AW-1:0]         r_ptr, n_ptr;
    logic [SNAP_CNT_W-1:0] r_cnt, n_cnt;
    t_out                  r_pend, n_pend;
    logic                  r_pend_valid, n_pend_valid;
    t_out                  r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    // fsm outputs
    logic          w_accept, w_commit, w_snap_adv, w_end_go;
    logic [AW-1:0] w_raddr;

    // ram
    t_entry        w_rd, w_wr;
    logic [EW-1:0] w_rdata;
    logic          w_we;

    // datapath
    logic [AW-1:0] w_idx;
    logic          w_in_range, w_is_self, w_used, w_anyrel;
    logic [31:0]   w_age;
    logic          w_resync, w_anyrel_eff, w_note_rel, w_reject, w_upd_ok;
    logic [15:0]   w_relseq_eff;
    logic          w_anyrel_new, w_rel_ok;
    t_entry        w_upd_word, w_rep_entry;
    logic [31:0]   w_rep_age;
    t_out          w_res;
    logic          w_slot_free;
    logic          w_snap_used, w_qualify, w_need_push;
    t_tier         w_snap_tier;
    t_out          w_snap_res;

    assign w_slot_free = !r_out_valid || !i_out_stall;

    nbt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_UNITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx),
        .i_wdata (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd = t_entry'(w_rdata);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in.cmd == CMD_SNAPSHOT) ? S_SNAP_ADDR : S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SNAP_ADDR: begin
                n_state = S_SNAP_EVAL;
            end
            S_SNAP_EVAL: begin
                if (w_snap_adv) begin
                    if (r_ptr == LAST_IDX ||
                        (w_qualify && r_cnt == SNAP_CNT_W'(RESULT_LIMIT - 1))) begin
                        n_state = S_SNAP_END;
                    end else begin
                        n_state = S_SNAP_ADDR;
                    end
                end
            end
            S_SNAP_END: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_commit   = 1'b0;
        w_snap_adv = 1'b0;
        w_end_go   = 1'b0;
        w_raddr    = r_ptr;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = !i_rst_n;
                w_raddr    = i_in.sender_id[AW-1:0];
            end
            S_EXEC: begin
                w_commit = w_slot_free;
                w_raddr  = w_idx;
            end
            S_SNAP_ADDR: begin
                w_raddr = r_ptr;
            end
            S_SNAP_EVAL: begin
                w_snap_adv = !w_need_push || w_slot_free;
                w_raddr    = r_ptr;
            end
            S_SNAP_END: begin
                w_end_go = w_slot_free;
            end
            default: begin
                w_raddr = r_ptr;
            end
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;

    // single-entry commands
    always_comb begin
        w_idx      = r_item.sender_id[AW-1:0];
        w_in_range = r_item.sender_id < UNIT_CNT;
        w_is_self  = r_item.sender_id == r_cfg_self;
        w_used     = w_in_range && r_in_use[w_idx];
        w_anyrel   = w_in_range && r_any_rel[w_idx];
        w_age      = r_item.now_ms - w_rd.last_heard;

        w_upd_ok     = w_in_range && !w_is_self;
        w_resync     = w_used && (w_age >= r_cfg_resync);
        w_anyrel_eff = w_anyrel && !w_resync;
        w_relseq_eff = w_resync ? 16'd0 : w_rd.relayed_seq;
        w_note_rel   = r_item.relayed_flag &&
                       (!w_anyrel_eff || seq_newer(r_item.beacon_seq, w_relseq_eff));
        w_reject     = w_used && !w_resync && !seq_newer(r_item.beacon_seq, w_rd.stored_seq);
        w_anyrel_new = w_note_rel || w_anyrel_eff;

        w_upd_word = w_rd;
        w_upd_word.relayed_seq = w_note_rel ? r_item.beacon_seq : w_relseq_eff;
        if (!w_reject) begin
            w_upd_word.initials   = {r_item.initial_first, r_item.initial_second};
            w_upd_word.stored_seq = r_item.beacon_seq;
            w_upd_word.last_heard = r_item.now_ms;
            w_upd_word.relayed    = r_item.relayed_flag;
        end

        w_rel_ok = !w_is_self && w_in_range && !r_item.relayed_flag &&
                   !(w_anyrel && !seq_newer(r_item.beacon_seq, w_rd.relayed_seq));

        // the update reports the entry as it stands after the write
        if (r_item.cmd == CMD_UPDATE && w_upd_ok && !w_reject) begin
            w_rep_entry = w_upd_word;
            w_rep_age   = 32'd0;
        end else begin
            w_rep_entry = w_rd;
            w_rep_age   = w_age;
        end

        w_res = '0;
        w_res.entry_id             = r_item.sender_id;
        w_res.entry_initial_first  = w_rep_entry.initials[15:8];
        w_res.entry_initial_second = w_rep_entry.initials[7:0];
        w_res.entry_seq            = w_rep_entry.stored_seq;
        w_res.entry_heard_ms       = w_rep_entry.last_heard;
        w_res.entry_via_relay      = w_rep_entry.relayed;
        w_res.age_tier = tier_of(w_rep_age, r_cfg_stale, r_cfg_ghost, r_cfg_gone);

        w_wr = w_rd;
        w_we = 1'b0;
        case (r_item.cmd)
            CMD_UPDATE: begin
                w_res.entry_valid = w_in_range && (w_used || w_upd_ok);
                if (w_is_self) begin
                    w_res.update_status = ST_SELF;
                end else if (!w_in_range || w_reject) begin
                    w_res.update_status = ST_OLD;
                end else if (!w_used) begin
                    w_res.update_status = ST_NEW;
                end else begin
                    w_res.update_status = ST_UPDATED;
                end
                w_wr = w_upd_word;
                w_we = w_commit && w_upd_ok;
            end
            CMD_RELAY: begin
                w_res.entry_valid = 1'b0;
                w_res.relay_ok    = w_rel_ok;
                w_wr.relayed_seq  = r_item.beacon_seq;
                w_we = w_commit && w_rel_ok;
            end
            default: begin
                w_res.entry_valid = w_used;
                if (!w_used) begin
                    w_res.age_tier = TIER_GONE;
                end
            end
        endcase
        if (!w_res.entry_valid) begin
            w_res.entry_id             = 8'd0;
            w_res.entry_initial_first  = 8'd0;
            w_res.entry_initial_second = 8'd0;
            w_res.entry_seq            = 16'd0;
            w_res.entry_heard_ms       = 32'd0;
            w_res.entry_via_relay      = 1'b0;
            if (r_item.cmd != CMD_TIER) begin
                w_res.age_tier = TIER_LIVE;
            end
        end
    end

    // snapshot walk
    always_comb begin
        w_snap_used = r_in_use[r_ptr];
        w_snap_tier = tier_of(r_item.now_ms - w_rd.last_heard,
                              r_cfg_stale, r_cfg_ghost, r_cfg_gone);
        w_qualify   = w_snap_used && (w_snap_tier != TIER_GONE);
        w_need_push = w_qualify && r_pend_valid;

        w_snap_res = '0;
        w_snap_res.age_tier             = w_snap_tier;
        w_snap_res.entry_valid          = 1'b1;
        w_snap_res.entry_id             = 8'(r_ptr);
        w_snap_res.entry_initial_first  = w_rd.initials[15:8];
        w_snap_res.entry_initial_second = w_rd.initials[7:0];
        w_snap_res.entry_seq            = w_rd.stored_seq;
        w_snap_res.entry_heard_ms       = w_rd.last_heard;
        w_snap_res.entry_via_relay      = w_rd.relayed;
    end

    // state updates
    always_comb begin
        n_in_use     = r_in_use;
        n_any_rel    = r_any_rel;
        n_ptr        = r_ptr;
        n_cnt        = r_cnt;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;

        if (w_accept) begin
            n_ptr        = '0;
            n_cnt        = '0;
            n_pend_valid = 1'b0;
        end

        if (w_commit) begin
            n_out       = w_res;
            n_out_valid = 1'b1;
            if (r_item.cmd == CMD_UPDATE && w_upd_ok) begin
                n_any_rel[w_idx] = w_anyrel_new;
                if (!w_reject) begin
                    n_in_use[w_idx] = 1'b1;
                end
            end
            if (r_item.cmd == CMD_RELAY && w_rel_ok) begin
                n_any_rel[w_idx] = 1'b1;
            end
        end

        if (w_snap_adv) begin
            n_ptr = r_ptr + AW'(1);
            if (w_qualify) begin
                // the held result is not the last one: push it out
                if (r_pend_valid) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                end
                n_pend       = w_snap_res;
                n_pend_valid = 1'b1;
                n_cnt        = r_cnt + SNAP_CNT_W'(1);
            end
        end

        if (w_end_go) begin
            if (r_pend_valid) begin
                n_out = r_pend;
            end else begin
                n_out = '0;
            end
            n_out.last_of_run = 1'b1;
            n_out_valid       = 1'b1;
            n_pend_valid      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_self   <= 8'd0;
            r_cfg_resync <= 32'd60000;
            r_cfg_stale  <= 32'd10000;
            r_cfg_ghost  <= 32'd30000;
            r_cfg_gone   <= 32'd120000;
            r_in_use     <= '0;
            r_any_rel    <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_in_use     <= n_in_use;
            r_any_rel    <= n_any_rel;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_SELF_ID: r_cfg_self   <= i_cfg_wdata[7:0];
                    CFG_RESYNC:  r_cfg_resync <= i_cfg_wdata;
                    CFG_STALE:   r_cfg_stale  <= i_cfg_wdata;
                    CFG_GHOST:   r_cfg_ghost  <= i_cfg_wdata;
                    CFG_GONE:    r_cfg_gone   <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in;
        end
        r_ptr  <= n_ptr;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[design/nbt_checker.sv]
// ----------------------------------------------------------------------------
// nbt_checker
// port-level assertions for the neighbor beacon table, bound to the top level
// ----------------------------------------------------------------------------
module nbt_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input nbt_pkg::t_out                  o_out
);

    import nbt_pkg::*;

    // a stalled result stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed or dropped");

    // one transaction in flight: no new input while a result is being built
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on the cycle after a transaction");

    // a result with no entry carries zero entry fields
    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.entry_valid |->
            o_out.entry_id == 8'd0 && o_out.entry_heard_ms == 32'd0 &&
            o_out.entry_seq == 16'd0 && !o_out.entry_via_relay)
        else $error("entry fields set without a valid entry");

    // relay answers report no entry and no update status
    a_relay_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.relay_ok |->
            !o_out.entry_valid && o_out.update_status == ST_NEW && !o_out.last_of_run)
        else $error("relay answer mixed with other result fields");

    // update and snapshot results never overlap
    a_status_not_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.update_status != ST_NEW |-> !o_out.last_of_run)
        else $error("update status on a snapshot result");

endmodule

bind neighbor_beacon_table nbt_checker u_nbt_checker (.*);
